/* rtl/core/grid_word_path_search_unit_macros.svh */
// Assertion macros for the grid word path search unit.
// Depends on nothing; included by the top level for its concurrent checks.
`ifndef GRID_WORD_PATH_SEARCH_UNIT_MACROS_SVH
`define GRID_WORD_PATH_SEARCH_UNIT_MACROS_SVH

// Same-cycle implication, held off during reset
`define GWPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gwps check failed");

// Next-cycle implication, held off during reset
`define GWPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gwps check failed");

`endif

/* rtl/core/gwps_pkg.sv */
// Shared types and codes of the grid word path search unit.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package gwps_pkg;

  // input item kinds
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_WORD = 1'b1;

  // configuration register indexes
  localparam logic CFG_ROW_COUNT = 1'b0;
  localparam logic CFG_COL_COUNT = 1'b1;

  localparam int unsigned CNT_W    = 5;
  localparam logic [CNT_W-1:0] CNT_RESET = 5'd16;

  typedef struct packed {
    logic load;     // write the item's letter into the grid
    logic capture;  // latch a word letter and fetch grid row 0
    logic step;     // process one mask row
  } gwps_cmd_t;

  typedef struct packed {
    logic last_row;
  } gwps_stat_t;

endpackage

/* rtl/core/grid_word_path_search_unit.sv */
// Sequence: a load item is taken in idle and gives no result. A word letter
// is captured, then swept with one grid row memory read per mask row, one row
// per cycle. A last letter's found strobe shows in the cycle after the sweep,
// which is also the first cycle a new item can be taken (busy low).
// Reset clears the reach mask and sets both counts to 16; grid letters are
// undefined until loaded. The receiver cannot stall; done_o lasts one cycle.
`timescale 1ns / 1ps

module grid_word_path_search_unit #(
  parameter int unsigned MAX_ROWS = 16,
  parameter int unsigned MAX_COLS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [gwps_pkg::CNT_W-1:0]  cfg_data_i,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        action_i,
  input  logic [3:0]                  cell_row_i,
  input  logic [3:0]                  cell_col_i,
  input  logic [7:0]                  letter_i,
  input  logic                        first_of_word_i,
  input  logic                        last_of_word_i,
  output logic                        done_o,
  output logic                        found_o
);
  import gwps_pkg::*;

  `include "grid_word_path_search_unit_macros.svh"

  gwps_cmd_t  cmd;
  gwps_stat_t stat;

  gwps_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .action_i (action_i),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  gwps_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .cell_row_i      (cell_row_i),
    .cell_col_i      (cell_col_i),
    .letter_i        (letter_i),
    .first_of_word_i (first_of_word_i),
    .last_of_word_i  (last_of_word_i),
    .done_o          (done_o),
    .found_o         (found_o)
  );

  // a result only follows a sweep
  `GWPS_ASSERT_NOW(a_done_after_sweep, clk_i, rst_ni, done_o, $past(busy_o) && !busy_o)
  // a word letter starts a sweep
  `GWPS_ASSERT_NEXT(a_word_sweeps, clk_i, rst_ni, start_i && !busy_o && action_i == ACT_WORD, busy_o)
  // a load never occupies the block
  `GWPS_ASSERT_NEXT(a_load_one_cycle, clk_i, rst_ni, start_i && !busy_o && action_i == ACT_LOAD, !busy_o)
  // strobes never come back to back
  `GWPS_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o)

endmodule

/* rtl/core/gwps_ctrl.sv */
// Sequencer of the grid word path search unit: idle / row sweep.
// Depends on gwps_pkg for the command and status structs.
`timescale 1ns / 1ps

module gwps_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                action_i,
  input  gwps_pkg::gwps_stat_t stat_i,
  output gwps_pkg::gwps_cmd_t  cmd_o,
  output logic                busy_o
);
  import gwps_pkg::*;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_SWEEP = 1'b1;

  logic state_q, state_d;
  logic accept;

  assign accept = start_i && (state_q == ST_IDLE);

  always_comb begin
    cmd_o.load    = accept && (action_i == ACT_LOAD);
    cmd_o.capture = accept && (action_i == ACT_WORD);
    cmd_o.step    = (state_q == ST_SWEEP);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.capture) state_d = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (stat_i.last_row) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

/* rtl/core/gwps_dp.sv */
// Datapath: grid row memory, rotating reach mask line, row match and result.
// Depends on gwps_pkg; driven by gwps_ctrl through command and status structs.
`timescale 1ns / 1ps

module gwps_dp #(
  parameter int unsigned MAX_ROWS = 16,
  parameter int unsigned MAX_COLS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gwps_pkg::gwps_cmd_t          cmd_i,
  output gwps_pkg::gwps_stat_t         stat_o,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [gwps_pkg::CNT_W-1:0]  cfg_data_i,
  input  logic [3:0]                  cell_row_i,
  input  logic [3:0]                  cell_col_i,
  input  logic [7:0]                  letter_i,
  input  logic                        first_of_word_i,
  input  logic                        last_of_word_i,
  output logic                        done_o,
  output logic                        found_o
);
  import gwps_pkg::*;

  localparam int unsigned RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CLW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned XW  = 7;  // holds any count or index up to 127
  localparam int unsigned ROW_BITS = MAX_COLS * 8;

  logic [CNT_W-1:0] row_cnt_q, col_cnt_q;

  logic [ROW_BITS-1:0] grid_mem [MAX_ROWS];
  logic [ROW_BITS-1:0] rd_data_q;
  logic [RW-1:0]       rd_addr;

  logic [MAX_COLS-1:0] reach_q [MAX_ROWS];
  logic [MAX_COLS-1:0] prev_q;
  logic [MAX_COLS-1:0] head, below, nb, match, col_act, row_mask;

  logic [RW-1:0] row_q;
  logic [7:0]    letter_q;
  logic          first_q, last_q;
  logic          any_q;
  logic          row_act;

  logic [XW-1:0] row_ext, col_ext;
  logic          load_ok;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= CNT_RESET;
      col_cnt_q <= CNT_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_ROW_COUNT) row_cnt_q <= cfg_data_i;
      if (cfg_idx_i == CFG_COL_COUNT) col_cnt_q <= cfg_data_i;
    end
  end

  // drop loads outside the active area
  assign row_ext = XW'(cell_row_i);
  assign col_ext = XW'(cell_col_i);
  assign load_ok = (row_ext < XW'(row_cnt_q)) && (row_ext < XW'(MAX_ROWS)) &&
                   (col_ext < XW'(col_cnt_q)) && (col_ext < XW'(MAX_COLS));

  assign stat_o.last_row = (row_q == RW'(MAX_ROWS - 1));

  // fetch row 0 on capture, then the row after the one in work
  always_comb begin
    if (cmd_i.capture || stat_o.last_row) rd_addr = '0;
    else                                  rd_addr = row_q + 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && load_ok) begin
      grid_mem[row_ext[RW-1:0]][col_ext[CLW-1:0]*8 +: 8] <= letter_i;
    end
    if (cmd_i.capture || cmd_i.step) begin
      rd_data_q <= grid_mem[rd_addr];
    end
  end

  // word letter fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      letter_q <= letter_i;
      first_q  <= first_of_word_i;
      last_q   <= last_of_word_i;
    end
  end

  for (genvar c = 0; c < MAX_COLS; c++) begin : g_col
    assign col_act[c] = (XW'(col_cnt_q) > XW'(c));
    assign match[c]   = col_act[c] && (rd_data_q[c*8 +: 8] == letter_q);
  end

  // head of the line is the old mask of the row in work
  assign head = reach_q[0];
  if (MAX_ROWS > 1) begin : g_below
    assign below = stat_o.last_row ? '0 : reach_q[1];
  end else begin : g_no_below
    assign below = '0;
  end

  assign nb       = (head << 1) | (head >> 1) | prev_q | below;
  assign row_act  = (XW'(row_q) < XW'(row_cnt_q));
  assign row_mask = row_act ? (match & (first_q ? '1 : nb)) : '0;

  // rotate the mask line: old row leaves the head, new row enters the tail
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_ROWS; i++) reach_q[i] <= '0;
      prev_q <= '0;
      row_q  <= '0;
      any_q  <= 1'b0;
    end else if (cmd_i.capture) begin
      prev_q <= '0;
      row_q  <= '0;
      any_q  <= 1'b0;
    end else if (cmd_i.step) begin
      for (int i = 0; i < MAX_ROWS - 1; i++) reach_q[i] <= reach_q[i+1];
      reach_q[MAX_ROWS-1] <= row_mask;
      prev_q <= head;
      row_q  <= stat_o.last_row ? '0 : row_q + 1'b1;
      any_q  <= any_q || (row_mask != '0);
    end
  end

  // result strobe after the last row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o  <= 1'b0;
      found_o <= 1'b0;
    end else begin
      done_o  <= cmd_i.step && stat_o.last_row && last_q;
      found_o <= any_q || (row_mask != '0);
    end
  end

endmodule
